>>> rtl/prms_pkg.sv
package prms_pkg;

	localparam int MaxWindow = 4096;
	localparam int CntW = 13;
	localparam int SumW = 48;
	localparam int RmsW = 24;
	localparam int QDepth = 2;

	localparam logic [1:0] RegRate = 2'd0;
	localparam logic [1:0] RegFund = 2'd1;
	localparam logic [1:0] RegLpf = 2'd2;

	// job handed from front to back
	typedef struct packed {
		logic ignored;
		logic closed;
		logic [SumW-1:0] sum;
		logic [CntW-1:0] cnt;
	} job_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DIV,
		ST_SQRT,
		ST_MUL,
		ST_OUT
	} back_st_t;

endpackage

>>> rtl/prms_front.sv
module prms_front (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_stall,
	input logic signed [15:0] sample,
	input logic [16:0] rate_q,
	input logic [15:0] fund_q,
	output logic job_valid,
	input logic job_ready,
	output prms_pkg::job_t job
);
	import prms_pkg::*;

	logic [SumW-1:0] sum_q;
	logic [CntW-1:0] cnt_q;
	logic [15:0] mag;
	logic [31:0] sq;
	logic [SumW-1:0] sum_n;
	logic [CntW-1:0] cnt_n;
	logic [28:0] lhs;
	logic [24:0] rhs;
	logic dis, closed;

	assign dis = fund_q <= 16'd256;
	assign mag = sample[15] ? 16'(-sample) : 16'(sample);
	assign sq = mag * mag;
	assign sum_n = sum_q + SumW'(sq);
	assign cnt_n = cnt_q + 1'b1;
	assign lhs = cnt_n * fund_q;
	assign rhs = {rate_q, 8'd0};
	assign closed = (29'(lhs) > 29'(rhs)) || (cnt_n >= CntW'(MaxWindow));

	assign in_stall = !job_ready;
	assign job_valid = in_valid;
	assign job.ignored = dis;
	assign job.closed = !dis && closed;
	assign job.sum = sum_n;
	assign job.cnt = cnt_n;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q <= '0;
			cnt_q <= '0;
		end else if (in_valid && job_ready && !dis) begin
			sum_q <= closed ? '0 : sum_n;
			cnt_q <= closed ? '0 : cnt_n;
		end
	end
endmodule

>>> rtl/prms_queue.sv
module prms_queue (
	input logic clk,
	input logic arst_n,
	input logic wr_valid,
	output logic wr_ready,
	input prms_pkg::job_t wr_data,
	output logic rd_valid,
	input logic rd_take,
	output prms_pkg::job_t rd_data
);
	import prms_pkg::*;

	job_t mem_q [QDepth];
	logic wp_q, rp_q;
	logic [1:0] cnt_q;
	logic wr, rd;

	assign wr_ready = cnt_q != 2'(QDepth);
	assign rd_valid = cnt_q != 2'd0;
	assign rd_data = mem_q[rp_q];
	assign wr = wr_valid && wr_ready;
	assign rd = rd_take && rd_valid;

	always_ff @(posedge clk) begin
		if (wr) mem_q[wp_q] <= wr_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0;
			rp_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			if (wr) wp_q <= !wp_q;
			if (rd) rp_q <= !rp_q;
			cnt_q <= cnt_q + 2'(wr) - 2'(rd);
		end
	end

`ifndef SYNTHESIS
	a_no_over: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= 2'(QDepth)) else $error("queue overflow");
	a_cnt_up: assert property (@(posedge clk) disable iff (!arst_n)
		(wr && !rd) |=> cnt_q == $past(cnt_q) + 2'd1) else $error("count");
	a_cnt_dn: assert property (@(posedge clk) disable iff (!arst_n)
		(rd && !wr) |=> cnt_q == $past(cnt_q) - 2'd1) else $error("count");
`endif
endmodule

>>> rtl/prms_back.sv
module prms_back (
	input logic clk,
	input logic arst_n,
	input logic job_valid,
	output logic job_take,
	input prms_pkg::job_t job,
	input logic [15:0] lpf_q,
	output logic out_valid,
	input logic out_stall,
	output logic [23:0] filtered_rms,
	output logic [23:0] window_rms,
	output logic window_closed,
	output logic ignored
);
	import prms_pkg::*;

	back_st_t st_q, st_n;
	logic [6:0] it_q;
	logic [63:0] num_q;     // dividend shifting into quotient
	logic [CntW:0] rem_q;
	logic [CntW-1:0] den_q;
	logic [63:0] rad_q;
	logic [31:0] root_q;
	logic [33:0] srem_q;
	logic [RmsW-1:0] filt_q, last_q, rms_q;
	logic out_load;
	logic [CntW:0] rem_sh;
	logic rem_ge;
	logic [33:0] srem_sh, trial;
	logic [40:0] acc;
	logic out_free;

	assign out_free = !out_valid || !out_stall;
	assign rem_sh = {rem_q[CntW-1:0], num_q[63]};
	assign rem_ge = rem_sh >= {1'b0, den_q};
	assign srem_sh = {srem_q[31:0], rad_q[63:62]};
	assign trial = {root_q, 2'b01};
	assign acc = 41'(rms_q) * 41'(17'h10000 - 17'(lpf_q)) + 41'(filt_q) * 41'(lpf_q);

	always_comb begin
		st_n = st_q;
		unique case (st_q)
			ST_IDLE: if (job_valid && out_free) begin
				if (!job.ignored && job.closed) st_n = ST_DIV;
				else st_n = ST_IDLE;
			end
			ST_DIV: if (it_q == 7'd63) st_n = ST_SQRT;
			ST_SQRT: if (it_q == 7'd31) st_n = ST_MUL;
			ST_MUL: st_n = ST_OUT;
			ST_OUT: if (out_free) st_n = ST_IDLE;
			default: st_n = ST_IDLE;
		endcase
	end

	always_comb begin
		job_take = (st_q == ST_IDLE) && out_free;
		out_load = ((st_q == ST_IDLE) && job_valid && out_free
			&& (job.ignored || !job.closed)) || ((st_q == ST_OUT) && out_free);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_IDLE;
			it_q <= '0;
			filt_q <= '0;
			last_q <= '0;
			out_valid <= 1'b0;
			filtered_rms <= '0;
			window_rms <= '0;
			window_closed <= 1'b0;
			ignored <= 1'b0;
		end else begin
			st_q <= st_n;
			if (out_load) out_valid <= 1'b1;
			else if (out_valid && !out_stall) out_valid <= 1'b0;
			unique case (st_q)
				ST_IDLE: if (job_valid && out_free) begin
					it_q <= '0;
					if (job.ignored) begin
						filtered_rms <= filt_q;
						window_rms <= last_q;
						window_closed <= 1'b0;
						ignored <= 1'b1;
					end else if (!job.closed) begin
						last_q <= '0;
						filtered_rms <= filt_q;
						window_rms <= '0;
						window_closed <= 1'b0;
						ignored <= 1'b0;
					end
				end
				ST_DIV: it_q <= (it_q == 7'd63) ? '0 : it_q + 1'b1;
				ST_SQRT: it_q <= it_q + 1'b1;
				ST_MUL: begin
					filt_q <= acc[39:16];
					last_q <= rms_q;
				end
				ST_OUT: if (out_free) begin
					filtered_rms <= filt_q;
					window_rms <= rms_q;
					window_closed <= 1'b1;
					ignored <= 1'b0;
				end
				default: ;
			endcase
		end
	end

	// restoring divide and bitwise root datapath
	always_ff @(posedge clk) begin
		if (st_q == ST_IDLE) begin
			num_q <= {job.sum, 16'd0};
			rem_q <= '0;
			den_q <= job.cnt;
		end else if (st_q == ST_DIV) begin
			num_q <= {num_q[62:0], rem_ge};
			rem_q <= rem_ge ? rem_sh - {1'b0, den_q} : rem_sh;
			if (it_q == 7'd63) begin
				rad_q <= {num_q[62:0], rem_ge};
				root_q <= '0;
				srem_q <= '0;
			end
		end else if (st_q == ST_SQRT) begin
			rad_q <= {rad_q[61:0], 2'b00};
			if (srem_sh >= trial) begin
				srem_q <= srem_sh - trial;
				root_q <= {root_q[30:0], 1'b1};
			end else begin
				srem_q <= srem_sh;
				root_q <= {root_q[30:0], 1'b0};
			end
			if (it_q == 7'd31) rms_q <= (srem_sh >= trial) ? {root_q[22:0], 1'b1}
				: {root_q[22:0], 1'b0};
		end
	end

`ifndef SYNTHESIS
	a_take_idle: assert property (@(posedge clk) disable iff (!arst_n)
		job_take |-> st_q == ST_IDLE) else $error("take outside idle");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> out_valid && $stable(window_rms))
		else $error("result lost");
	a_div_len: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == ST_DIV && it_q == 7'd63) |=> st_q == ST_SQRT) else $error("div");
`endif
endmodule

>>> rtl/periodic_rms_with_lowpass_core.sv
// Per-period true-RMS meter with a first-order low-pass on the window RMS. Each
// item gives one result. An item that does not close a window (or arrives while
// fundamental_q8 <= 256) is answered in the cycle after it leaves the two-entry
// queue; a window close is answered once the back end has gone through a
// 64-step restoring divide of sum*65536 by the count, a 32-step bitwise square
// root, a filter multiply state and an output state. The front end keeps
// accepting into the queue, until it is full, while the back end works.
module periodic_rms_with_lowpass_core (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_stall,
	input logic signed [15:0] sample,
	output logic out_valid,
	input logic out_stall,
	output logic [23:0] filtered_rms,
	output logic [23:0] window_rms,
	output logic window_closed,
	output logic ignored,
	input logic cfg_valid,
	output logic cfg_ready,
	input logic [1:0] cfg_index,
	input logic [31:0] cfg_data
);
	import prms_pkg::*;

	logic [16:0] rate_q;
	logic [15:0] fund_q, lpf_q;
	logic fq_valid, fq_ready, bq_valid, bq_take;
	job_t fq_job, bq_job;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rate_q <= 17'd1000;
			fund_q <= 16'd12800;
			lpf_q <= '0;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				RegRate: rate_q <= cfg_data[16:0];
				RegFund: fund_q <= cfg_data[15:0];
				RegLpf: lpf_q <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	prms_front u_front (
		.clk, .arst_n, .in_valid, .in_stall, .sample, .rate_q, .fund_q,
		.job_valid(fq_valid), .job_ready(fq_ready), .job(fq_job)
	);

	prms_queue u_queue (
		.clk, .arst_n, .wr_valid(fq_valid), .wr_ready(fq_ready), .wr_data(fq_job),
		.rd_valid(bq_valid), .rd_take(bq_take), .rd_data(bq_job)
	);

	prms_back u_back (
		.clk, .arst_n, .job_valid(bq_valid), .job_take(bq_take), .job(bq_job),
		.lpf_q, .out_valid, .out_stall, .filtered_rms, .window_rms,
		.window_closed, .ignored
	);
endmodule

>>> dv/tb.sv
`timescale 1ns / 1ps

module tb;
	import prms_pkg::*;

	localparam logic [1:0] RegNone = 2'd3;
	localparam int CycleLimit = 1500000;

	typedef struct {
		logic [23:0] filtered_rms;
		logic [23:0] window_rms;
		logic window_closed;
		logic ignored;
	} rms_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic signed [15:0] sample = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [23:0] filtered_rms;
	logic [23:0] window_rms;
	logic window_closed;
	logic ignored;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [1:0] cfg_index = '0;
	logic [31:0] cfg_data = '0;

	periodic_rms_with_lowpass_core u_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .sample(sample),
		.out_valid(out_valid), .out_stall(out_stall),
		.filtered_rms(filtered_rms), .window_rms(window_rms),
		.window_closed(window_closed), .ignored(ignored),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	// meter model state and registers
	logic [16:0] rate_reg = 17'd1000;
	logic [15:0] fund_reg = 16'd12800;
	logic [15:0] lpf_reg = 16'd0;
	logic [SumW-1:0] acc_sum = '0;
	logic [CntW-1:0] acc_cnt = '0;
	logic [23:0] filt_val = '0;
	logic [23:0] last_rms = '0;

	logic signed [15:0] sample_backlog[$];
	rms_result_t rms_expected[$];
	int src_pct = 0;
	int sink_pct = 0;
	logic sink_hold = 1'b0;
	logic hold_go = 1'b0;
	logic took_in = 1'b0;
	int errors = 0;
	int cyc = 0;

	initial begin
		forever #1 clk = ~clk;
	end

	function automatic logic [63:0] floor_root(input logic [63:0] v);
		logic [63:0] r;
		logic [63:0] b;
		r = '0;
		b = 64'h4000_0000_0000_0000;
		while (b > v)
			b = b >> 2;
		while (b != 0) begin
			if (v >= r + b) begin
				v = v - (r + b);
				r = (r >> 1) + b;
			end else begin
				r = r >> 1;
			end
			b = b >> 2;
		end
		return r;
	endfunction

	function automatic rms_result_t meter_step(input logic signed [15:0] s);
		rms_result_t res;
		logic [16:0] mag;
		logic [63:0] mean;
		logic [63:0] acc;
		logic [23:0] rms;
		logic closed;
		rms = '0;
		if (fund_reg <= 16'd256) begin
			res.filtered_rms = filt_val;
			res.window_rms = last_rms;
			res.window_closed = 1'b0;
			res.ignored = 1'b1;
			return res;
		end
		mag = s[15] ? 17'h10000 - {1'b0, s} : {1'b0, s};
		acc_sum = acc_sum + 48'(mag) * 48'(mag);
		acc_cnt = acc_cnt + 1'b1;
		closed = (64'(acc_cnt) * 64'(fund_reg) > 64'(rate_reg) * 64'd256) ||
			(acc_cnt >= MaxWindow);
		if (closed) begin
			mean = {acc_sum, 16'h0} / 64'(acc_cnt);
			rms = 24'(floor_root(mean));
			acc_sum = '0;
			acc_cnt = '0;
			acc = 64'(rms) * (64'd65536 - 64'(lpf_reg)) + 64'(filt_val) * 64'(lpf_reg);
			filt_val = acc[39:16];
		end
		last_rms = rms;
		res.filtered_rms = filt_val;
		res.window_rms = rms;
		res.window_closed = closed;
		res.ignored = 1'b0;
		return res;
	endfunction

	// sender
	always @(negedge clk) begin
		if (!in_valid || took_in) begin
			if (arst_n && sample_backlog.size() > 0 && $urandom_range(99) >= src_pct) begin
				sample <= sample_backlog.pop_front();
				in_valid <= 1'b1;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// receiver
	always @(negedge clk) begin
		out_stall <= sink_hold || ($urandom_range(99) < sink_pct);
	end

	// long receiver hold, counted on its own
	initial begin
		wait (hold_go);
		sink_hold = 1'b1;
		repeat (400) @(posedge clk);
		sink_hold = 1'b0;
	end

	// prediction on input, checking on output
	always @(posedge clk) begin
		rms_result_t want;
		took_in <= in_valid && !in_stall;
		if (arst_n && in_valid && !in_stall)
			rms_expected.push_back(meter_step(sample));
		if (arst_n && out_valid && !out_stall) begin
			if (rms_expected.size() == 0) begin
				$error("result item with nothing expected");
				errors++;
			end else begin
				want = rms_expected.pop_front();
				if (filtered_rms !== want.filtered_rms) begin
					$error("filtered_rms exp %0d got %0d", want.filtered_rms, filtered_rms);
					errors++;
				end
				if (window_rms !== want.window_rms) begin
					$error("window_rms exp %0d got %0d", want.window_rms, window_rms);
					errors++;
				end
				if (window_closed !== want.window_closed) begin
					$error("window_closed exp %0b got %0b", want.window_closed, window_closed);
					errors++;
				end
				if (ignored !== want.ignored) begin
					$error("ignored exp %0b got %0b", want.ignored, ignored);
					errors++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cyc <= cyc + 1;
		if (cyc > CycleLimit) begin
			$display("tb: failure");
			$finish;
		end
	end

	task automatic reg_write(input logic [1:0] idx, input logic [31:0] val);
		@(negedge clk);
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data = val;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			RegRate: rate_reg = val[16:0];
			RegFund: fund_reg = val[15:0];
			RegLpf: lpf_reg = val[15:0];
			default: ;
		endcase
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	// junk in the bits above each register width
	task automatic write_all(input logic [16:0] r, input logic [15:0] f, input logic [15:0] k);
		reg_write(RegRate, {15'($urandom_range(32767)), r});
		reg_write(RegFund, {16'($urandom), f});
		reg_write(RegLpf, {16'($urandom), k});
	endtask

	task automatic drain();
		while (sample_backlog.size() > 0 || in_valid || rms_expected.size() > 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	function automatic logic signed [15:0] rand_sample();
		case ($urandom_range(3))
			0: return $urandom_range(1) ? 16'sh8000 : 16'sh7fff;
			1: return 16'($signed($urandom_range(64)) - 32);
			default: return 16'($urandom);
		endcase
	endfunction

	initial begin
		logic [16:0] r;
		logic [15:0] f;
		logic [15:0] k;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// defaults, window of 21
		foreach (sample_backlog[i]) ;
		repeat (21) sample_backlog.push_back(16'sh8000);
		drain();
		// three-sample windows, extremes and zero
		write_all(17'd100, 16'd12800, 16'd0);
		sample_backlog.push_back(16'sh8000);
		sample_backlog.push_back(16'sh7fff);
		sample_backlog.push_back(16'sh8000);
		sample_backlog.push_back(16'sh0000);
		sample_backlog.push_back(16'sh0000);
		sample_backlog.push_back(16'sh0000);
		drain();
		write_all(17'd100, 16'd12800, 16'hffff);
		sample_backlog.push_back(16'sh0001);
		sample_backlog.push_back(16'shffff);
		sample_backlog.push_back(16'sh7fff);
		drain();
		// disabled at the 1 Hz boundary and at zero
		reg_write(RegFund, 32'd256);
		reg_write(RegNone, $urandom);
		sample_backlog.push_back(16'sh1234);
		sample_backlog.push_back(16'sh8000);
		drain();
		reg_write(RegFund, 32'd0);
		sample_backlog.push_back(16'sh7fff);
		drain();
		// zero rate: every sample closes
		write_all(17'd0, 16'd257, 16'd32768);
		sample_backlog.push_back(16'sh8000);
		sample_backlog.push_back(16'sh0003);
		drain();

		for (int ph = 0; ph < 12; ph++) begin
			case ($urandom_range(9))
				0: r = 17'd0;
				1: r = 17'd100000;
				2: r = 17'h1ffff;
				3: r = 17'd1;
				default: r = 17'($urandom_range(300, 1));
			endcase
			case ($urandom_range(9))
				0: f = 16'd256;
				1: f = 16'd257;
				2: f = 16'hffff;
				3: f = 16'($urandom_range(300));
				default: f = 16'($urandom_range(65535, 5000));
			endcase
			case ($urandom_range(3))
				0: k = 16'd0;
				1: k = 16'hffff;
				default: k = 16'($urandom);
			endcase
			write_all(r, f, k);
			if ($urandom_range(3) == 0)
				reg_write(RegNone, $urandom);
			src_pct = (ph % 4 == 1) ? 75 : (ph % 4 == 3) ? 23 : 0;
			sink_pct = (ph % 4 == 2) ? 75 : (ph % 4 == 3) ? 23 : 0;
			repeat (95) sample_backlog.push_back(rand_sample());
			if (ph == 4) begin
				// receiver holds off while the sender keeps offering
				hold_go = 1'b1;
			end
			drain();
		end

		if (errors == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
